>>> src/tps_pkg.sv
// Package: constants and types for the task priority scheduler.
package tps_pkg;

  localparam int NumTasks = 64;
  localparam int IdxW = $clog2(NumTasks);

  localparam logic [31:0] AlarmBit    = 32'h0000_2000;
  localparam logic [31:0] Unblockable = 32'h0004_0100;

  localparam logic [2:0] StRunning       = 3'd0;
  localparam logic [2:0] StInterruptible = 3'd1;

  localparam logic [6:0] PrioReset = 7'd15;

  typedef enum logic [1:0] {
    ReqLoad     = 2'd0,
    ReqSchedule = 2'd1,
    ReqTick     = 2'd2,
    ReqUnused   = 2'd3
  } req_e;

  // One task slot as held in the slot memory.
  typedef struct packed {
    logic        present;
    logic [2:0]  run_state;
    logic [7:0]  counter;
    logic [6:0]  prio;
    logic [30:0] alarm;
    logic [31:0] pending;
    logic [31:0] blocked;
  } slot_t;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [5:0]  task_index;
    logic        present;
    logic [2:0]  run_state;
    logic [7:0]  counter_value;
    logic [6:0]  priority_value;
    logic [30:0] alarm_time;
    logic [31:0] signal_bits;
    logic [31:0] blocked_bits;
    logic [30:0] now_jiffies;
    logic        user_mode;
  } req_t;

  typedef struct packed {
    logic [5:0] chosen_task;
    logic       switched;
    logic       recomputed;
    logic [7:0] counter_left;
  } rsp_t;

  typedef enum logic [3:0] {
    StClear,
    StIdle,
    StTickRd,
    StTickWr,
    StWakeRd,
    StWakeWr,
    StPick,
    StRecRd,
    StRecWr,
    StCurRd,
    StOut
  } state_e;

endpackage

>>> src/tps_if.sv
// Interfaces: valid/ready channels for request and result items.
interface tps_req_if;
  import tps_pkg::*;
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface tps_rsp_if;
  import tps_pkg::*;
  logic valid;
  logic ready;
  rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> src/task_priority_scheduler.sv
// Top level: counter-based round-robin task scheduler over a slot memory.
// Flow: a load writes one slot; a tick reads and rewrites the running slot; a pass
//   walks the slot memory to wake tasks, then again to pick, and if recomputing walks
//   it once more and picks again. One item at a time; the single-port
//   slot memory sets the pace. Result held in an output register.
// Reset: a clearing pass of NumTasks cycles writes every slot before the
//   first item is accepted.
module task_priority_scheduler (
  input logic clk_i,
  input logic rst_ni,
  tps_req_if.sink   req_i,
  tps_rsp_if.source rsp_o
);
  import tps_pkg::*;

  // Slot memory, one port, registered read.
  slot_t               mem [NumTasks];
  logic [IdxW-1:0]     addr;
  logic                we;
  slot_t               wdata;
  slot_t               rdata_q;

  always_ff @(posedge clk_i) begin
    if (we) mem[addr] <= wdata;
    rdata_q <= mem[addr];
  end

  state_e          state_q, state_d;
  req_t            req_q, req_d;
  logic [IdxW-1:0] idx_q, idx_d;       // walk index
  logic [IdxW-1:0] run_q, run_d;       // running task
  logic [IdxW-1:0] win_q, win_d;
  logic [8:0]      best_q, best_d;     // bit 8: none found yet
  logic            rec_q, rec_d;
  logic            sw_q, sw_d;
  logic            ovalid_q, ovalid_d;
  rsp_t            out_q, out_d;

  // Pick pipeline tags: which slot the registered read data belongs to.
  logic            pick_v_q;
  logic            pick_last_q;
  logic [IdxW-1:0] pick_i_q;
  logic            issued_last_q;

  logic runnable;
  logic wake;
  slot_t mod;
  logic alarm_hit;

  always_comb begin
    // Pick candidate: present, running, counter strictly above best so far.
    runnable = rdata_q.present && (rdata_q.run_state == StRunning) &&
               (best_q[8] || ({1'b0, rdata_q.counter} > best_q));
    alarm_hit = (rdata_q.alarm != '0) && (rdata_q.alarm < req_q.now_jiffies);
    mod = rdata_q;
    if (alarm_hit) begin
      mod.pending = rdata_q.pending | AlarmBit;
      mod.alarm   = '0;
    end
    wake = ((mod.pending & ~(~Unblockable & mod.blocked)) != '0) &&
           (mod.run_state == StInterruptible);
    if (wake) mod.run_state = StRunning;
  end

  always_comb begin
    state_d  = state_q;
    req_d    = req_q;
    idx_d    = idx_q;
    run_d    = run_q;
    win_d    = win_q;
    best_d   = best_q;
    rec_d    = rec_q;
    sw_d     = sw_q;
    ovalid_d = ovalid_q;
    out_d    = out_q;
    addr     = idx_q;
    we       = 1'b0;
    wdata    = rdata_q;
    req_i.ready = 1'b0;
    if (ovalid_q && rsp_o.ready) ovalid_d = 1'b0;

    unique case (state_q)
      StClear: begin
        we    = 1'b1;
        wdata = '{present: (idx_q == '0), run_state: StRunning, counter: '0,
                  prio: PrioReset, alarm: '0, pending: '0, blocked: '0};
        idx_d = idx_q + 1'b1;
        if (idx_q == IdxW'(NumTasks - 1)) state_d = StIdle;
      end
      StIdle: begin
        req_i.ready = !ovalid_q || rsp_o.ready;
        if (req_i.valid && req_i.ready) begin
          req_d = req_i.data;
          sw_d  = 1'b0;
          rec_d = 1'b0;
          unique case (req_e'(req_i.data.req_type))
            ReqLoad: begin
              addr  = req_i.data.task_index[IdxW-1:0];
              we    = 1'b1;
              wdata = '{present: req_i.data.present,
                        run_state: req_i.data.run_state,
                        counter: req_i.data.counter_value,
                        prio: req_i.data.priority_value,
                        alarm: req_i.data.alarm_time,
                        pending: req_i.data.signal_bits,
                        blocked: req_i.data.blocked_bits};
              state_d = StCurRd;
            end
            ReqSchedule: begin
              sw_d    = 1'b1;
              idx_d   = IdxW'(NumTasks - 1);
              addr    = IdxW'(NumTasks - 1);
              state_d = StWakeRd;
            end
            ReqTick: begin
              addr    = run_q;
              state_d = StTickRd;
            end
            ReqUnused: begin
              state_d = StCurRd;
            end
            default: state_d = StCurRd;
          endcase
        end
      end
      StTickRd: begin
        addr    = run_q;
        state_d = StTickWr;
      end
      StTickWr: begin
        addr = run_q;
        we   = 1'b1;
        if (rdata_q.counter > 8'd1) begin
          wdata.counter = rdata_q.counter - 8'd1;
          state_d = StCurRd;
        end else begin
          wdata.counter = '0;
          if (req_q.user_mode) begin
            sw_d    = 1'b1;
            idx_d   = IdxW'(NumTasks - 1);
            state_d = StWakeRd;
          end else begin
            state_d = StCurRd;
          end
        end
      end
      StWakeRd: begin
        addr    = idx_q;
        state_d = StWakeWr;
      end
      StWakeWr: begin
        addr = idx_q;
        if (rdata_q.present) begin
          we    = 1'b1;
          wdata = mod;
        end
        if (idx_q == IdxW'(1)) begin
          idx_d   = IdxW'(NumTasks - 1);
          addr    = IdxW'(NumTasks - 1);
          best_d  = 9'h100;
          win_d   = '0;
          state_d = StPick;
          if (we) addr = idx_q;
        end else begin
          idx_d   = idx_q - 1'b1;
          state_d = StWakeRd;
        end
      end
      StPick: begin
        // Read issued at idx_q; the slot read in the previous cycle is judged now.
        addr = idx_q;
        if (pick_v_q) begin
          if (runnable) begin
            best_d = {1'b0, rdata_q.counter};
            win_d  = pick_i_q;
          end
        end
        if (pick_last_q) begin
          // Final decision uses the updated best/win values.
          if (!best_d[8] && best_d[7:0] == '0 && !rec_q) begin
            rec_d   = 1'b1;
            idx_d   = IdxW'(NumTasks - 1);
            state_d = StRecRd;
          end else begin
            run_d   = win_d;
            state_d = StCurRd;
          end
        end else if (idx_q != IdxW'(1)) begin
          idx_d = idx_q - 1'b1;
        end
      end
      StRecRd: begin
        addr    = idx_q;
        state_d = StRecWr;
      end
      StRecWr: begin
        addr = idx_q;
        if (rdata_q.present) begin
          we = 1'b1;
          wdata.counter = (rdata_q.counter >> 1) + {1'b0, rdata_q.prio};
        end
        if (idx_q == IdxW'(1)) begin
          idx_d   = IdxW'(NumTasks - 1);
          best_d  = 9'h100;
          win_d   = '0;
          state_d = StPick;
        end else begin
          idx_d   = idx_q - 1'b1;
          state_d = StRecRd;
        end
      end
      StCurRd: begin
        addr    = run_q;
        state_d = StOut;
      end
      StOut: begin
        addr = run_q;
        if (!ovalid_q || rsp_o.ready) begin
          ovalid_d = 1'b1;
          out_d    = '{chosen_task: 6'(run_q), switched: sw_q,
                       recomputed: rec_q, counter_left: rdata_q.counter};
          state_d  = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pick_v_q      <= 1'b0;
      pick_last_q   <= 1'b0;
      pick_i_q      <= '0;
      issued_last_q <= 1'b0;
    end else if (state_q == StPick && !pick_last_q) begin
      pick_v_q      <= !issued_last_q;
      pick_i_q      <= idx_q;
      pick_last_q   <= issued_last_q;
      issued_last_q <= (idx_q == IdxW'(1));
    end else begin
      pick_v_q      <= 1'b0;
      pick_last_q   <= 1'b0;
      issued_last_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StClear;
      idx_q    <= '0;
      run_q    <= '0;
      win_q    <= '0;
      best_q   <= 9'h100;
      rec_q    <= 1'b0;
      sw_q     <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      idx_q    <= idx_d;
      run_q    <= run_d;
      win_q    <= win_d;
      best_q   <= best_d;
      rec_q    <= rec_d;
      sw_q     <= sw_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q <= req_d;
    out_q <= out_d;
  end

  assign rsp_o.valid = ovalid_q;
  assign rsp_o.data  = out_q;

endmodule

>>> test/tb_task_priority_scheduler.sv
// Testbench: random and directed items against a built-in scheduler predictor.
`timescale 1ns / 100ps

module tb_task_priority_scheduler;
  import tps_pkg::*;

  logic clk_i;
  logic rst_ni;

  tps_req_if req_if ();
  tps_rsp_if rsp_if ();

  task_priority_scheduler u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if.sink),
    .rsp_o (rsp_if.source)
  );

  // Predictor copy of the slot table.
  logic        mdl_present [NumTasks];
  logic [2:0]  mdl_state   [NumTasks];
  logic [7:0]  mdl_counter [NumTasks];
  logic [6:0]  mdl_prio    [NumTasks];
  logic [30:0] mdl_alarm   [NumTasks];
  logic [31:0] mdl_pending [NumTasks];
  logic [31:0] mdl_blocked [NumTasks];
  logic [5:0]  mdl_running;

  req_t pending_items[$];
  rsp_t expected_rsp[$];

  int errors = 0;
  int n_checked = 0;
  int n_passes = 0;
  int n_recomputes = 0;
  int idle_cycles = 0;
  bit hold_rx = 0;
  bit in_acc = 0;
  bit out_acc = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Largest counter among present running slots; higher index wins ties.
  function automatic void pick_winner(output logic [5:0] win, output int best);
    best = -1;
    win = '0;
    for (int i = NumTasks - 1; i >= 1; i--) begin
      if (mdl_present[i] && mdl_state[i] == StRunning && int'(mdl_counter[i]) > best) begin
        best = int'(mdl_counter[i]);
        win = 6'(i);
      end
    end
  endfunction

  // Alarm post, wake-up, pick, one optional recompute.
  function automatic bit sched_pass(logic [30:0] now);
    logic [5:0] win;
    int best;
    bit rc;
    rc = 0;
    for (int i = NumTasks - 1; i >= 1; i--) begin
      if (mdl_present[i]) begin
        if (mdl_alarm[i] != 0 && mdl_alarm[i] < now) begin
          mdl_pending[i] |= AlarmBit;
          mdl_alarm[i] = '0;
        end
        if ((mdl_pending[i] & ~(~Unblockable & mdl_blocked[i])) != 0 &&
            mdl_state[i] == StInterruptible)
          mdl_state[i] = StRunning;
      end
    end
    pick_winner(win, best);
    if (best == 0) begin
      for (int i = NumTasks - 1; i >= 1; i--)
        if (mdl_present[i]) mdl_counter[i] = (mdl_counter[i] >> 1) + 8'(mdl_prio[i]);
      rc = 1;
      pick_winner(win, best);
    end
    mdl_running = win;
    return rc;
  endfunction

  function automatic rsp_t predict_item(req_t it);
    rsp_t r;
    r = '0;
    case (req_e'(it.req_type))
      ReqLoad: begin
        mdl_present[it.task_index] = it.present;
        mdl_state[it.task_index]   = it.run_state;
        mdl_counter[it.task_index] = it.counter_value;
        mdl_prio[it.task_index]    = it.priority_value;
        mdl_alarm[it.task_index]   = it.alarm_time;
        mdl_pending[it.task_index] = it.signal_bits;
        mdl_blocked[it.task_index] = it.blocked_bits;
      end
      ReqSchedule: begin
        r.switched = 1;
        r.recomputed = sched_pass(it.now_jiffies);
      end
      ReqTick: begin
        if (mdl_counter[mdl_running] > 1) begin
          mdl_counter[mdl_running]--;
        end else begin
          mdl_counter[mdl_running] = '0;
          if (it.user_mode) begin
            r.switched = 1;
            r.recomputed = sched_pass(it.now_jiffies);
          end
        end
      end
      default: ;
    endcase
    r.chosen_task = mdl_running;
    r.counter_left = mdl_counter[mdl_running];
    return r;
  endfunction

  function automatic req_t rand_item();
    req_t it;
    it.req_type       = 2'($urandom_range(0, 3));
    it.task_index     = 6'($urandom);
    it.present        = 1'($urandom);
    it.run_state      = 3'($urandom);
    it.counter_value  = 8'($urandom);
    it.priority_value = 7'($urandom);
    it.alarm_time     = 31'($urandom);
    it.signal_bits    = $urandom;
    it.blocked_bits   = $urandom;
    it.now_jiffies    = 31'($urandom);
    it.user_mode      = 1'($urandom);
    return it;
  endfunction

  // Well-formed load: mostly runnable or interruptible tasks, small counters.
  function automatic req_t load_item(int idx);
    req_t it;
    it = rand_item();
    it.req_type = ReqLoad;
    it.task_index = 6'(idx);
    it.present = ($urandom_range(0, 7) != 0);
    it.run_state = ($urandom_range(0, 9) < 7) ? 3'($urandom_range(0, 1)) : 3'($urandom);
    it.counter_value = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 4));
    if ($urandom_range(0, 2) == 0) it.alarm_time = 31'($urandom_range(0, 3000));
    if ($urandom_range(0, 2) != 0) it.signal_bits = $urandom & 32'h0004_2100;
    return it;
  endfunction

  function automatic req_t ctl_item(req_e kind);
    req_t it;
    it = rand_item();
    it.req_type = kind;
    if ($urandom_range(0, 1)) it.now_jiffies = 31'($urandom_range(0, 4000));
    return it;
  endfunction

  // Handshakes seen at the rising edge, used by the falling-edge drivers.
  always @(posedge clk_i) begin
    in_acc  <= req_if.valid && req_if.ready;
    out_acc <= rsp_if.valid && rsp_if.ready;
  end

  // Driver: inputs change on the falling edge.
  int gap_tx = 0;
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
    end else if (req_if.valid && !in_acc) begin
      // hold the offered item until it is taken
    end else if (gap_tx > 0) begin
      gap_tx <= gap_tx - 1;
      req_if.valid <= 1'b0;
    end else if (pending_items.size() > 0) begin
      req_if.data <= pending_items.pop_front();
      req_if.valid <= 1'b1;
      gap_tx <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5);
    end else begin
      req_if.valid <= 1'b0;
    end
  end

  // Receiver ready: random stalls, plus one long hold-off.
  int gap_rx = 0;
  always @(negedge clk_i) begin
    if (!rst_ni || hold_rx) begin
      rsp_if.ready <= 1'b0;
    end else if (out_acc) begin
      gap_rx <= $urandom_range(0, 5);
      rsp_if.ready <= 1'b0;
    end else if (gap_rx > 0) begin
      gap_rx <= gap_rx - 1;
      rsp_if.ready <= 1'b0;
    end else begin
      rsp_if.ready <= 1'b1;
    end
  end

  // Monitor: predict on input accept, check on result accept.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (req_if.valid && req_if.ready) expected_rsp.push_back(predict_item(req_if.data));
      if (rsp_if.valid && rsp_if.ready) begin
        if (expected_rsp.size() == 0) begin
          $display("%0t: unexpected result %p", $time, rsp_if.data);
          errors++;
        end else begin
          rsp_t e;
          e = expected_rsp.pop_front();
          if (rsp_if.data.chosen_task !== e.chosen_task)
            $display("%0t: chosen_task exp %0d got %0d", $time, e.chosen_task,
                     rsp_if.data.chosen_task);
          if (rsp_if.data.switched !== e.switched)
            $display("%0t: switched exp %0d got %0d", $time, e.switched, rsp_if.data.switched);
          if (rsp_if.data.recomputed !== e.recomputed)
            $display("%0t: recomputed exp %0d got %0d", $time, e.recomputed,
                     rsp_if.data.recomputed);
          if (rsp_if.data.counter_left !== e.counter_left)
            $display("%0t: counter_left exp %0d got %0d", $time, e.counter_left,
                     rsp_if.data.counter_left);
          if (rsp_if.data !== e) errors++;
          n_checked++;
          if (e.switched) n_passes++;
          if (e.recomputed) n_recomputes++;
        end
      end
    end
  end

  // Watchdog on cycles without any accepted item.
  always @(posedge clk_i) begin
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) || !rst_ni)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("%0t: watchdog, no progress", $time);
      $display("** task_priority_scheduler: FAILED **");
      $finish;
    end
  end

  // Long receiver hold-off while items keep coming.
  initial begin
    wait (rst_ni);
    repeat (2000) @(posedge clk_i);
    hold_rx = 1;
    repeat (3000) @(posedge clk_i);
    hold_rx = 0;
  end

  initial begin
    req_t it;
    req_if.valid = 1'b0;
    req_if.data = '0;
    rsp_if.ready = 1'b0;
    for (int i = 0; i < NumTasks; i++) begin
      mdl_present[i] = (i == 0);
      mdl_state[i] = StRunning;
      mdl_counter[i] = '0;
      mdl_prio[i] = PrioReset;
      mdl_alarm[i] = '0;
      mdl_pending[i] = '0;
      mdl_blocked[i] = '0;
    end
    mdl_running = '0;
    rst_ni = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: empty table schedule, tick on slot 0, extremes, unused type.
    pending_items.push_back(ctl_item(ReqSchedule));
    it = ctl_item(ReqTick); it.user_mode = 1; pending_items.push_back(it);
    it = ctl_item(ReqUnused); pending_items.push_back(it);
    it = load_item(63); it.present = 1; it.run_state = StRunning; it.counter_value = 8'hff;
    it.priority_value = 7'h7f; it.alarm_time = '1; it.signal_bits = '1; it.blocked_bits = '1;
    pending_items.push_back(it);
    it = load_item(1); it.present = 1; it.run_state = StRunning; it.counter_value = 8'hff;
    pending_items.push_back(it);  // tie: 63 wins
    pending_items.push_back(ctl_item(ReqSchedule));
    it = ctl_item(ReqTick); it.user_mode = 0; pending_items.push_back(it);
    // Interruptible with blocked kill: still wakes.
    it = load_item(5); it.present = 1; it.run_state = StInterruptible; it.counter_value = 0;
    it.signal_bits = 32'h100; it.blocked_bits = '1; it.alarm_time = 0; pending_items.push_back(it);
    // Alarm that expires.
    it = load_item(7); it.present = 1; it.run_state = StInterruptible; it.alarm_time = 5;
    it.signal_bits = 0; it.blocked_bits = 0; pending_items.push_back(it);
    it = ctl_item(ReqSchedule); it.now_jiffies = 10; pending_items.push_back(it);
    // Zero counters with priority 0: recompute leaves zero.
    it = load_item(63); it.present = 0; pending_items.push_back(it);
    it = load_item(1); it.counter_value = 0; it.priority_value = 0; it.present = 1;
    it.run_state = StRunning; pending_items.push_back(it);
    it = load_item(5); it.present = 0; pending_items.push_back(it);
    it = load_item(7); it.present = 0; pending_items.push_back(it);
    pending_items.push_back(ctl_item(ReqSchedule));
    // Slot 0 load, and run state above stopped.
    it = load_item(0); it.present = 0; it.counter_value = 8'd3; pending_items.push_back(it);
    it = load_item(2); it.present = 1; it.run_state = 3'd7; pending_items.push_back(it);
    it = ctl_item(ReqTick); it.user_mode = 1; pending_items.push_back(it);

    // Random: well-formed loads, schedules and ticks with some noise.
    for (int n = 0; n < 480; n++) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: pending_items.push_back(load_item($urandom_range(0, 63)));
        4: pending_items.push_back(ctl_item(ReqSchedule));
        5, 6, 7: pending_items.push_back(ctl_item(ReqTick));
        8: pending_items.push_back(load_item($urandom_range(1, 8)));
        default: pending_items.push_back(rand_item());
      endcase
    end

    wait (pending_items.size() == 0 && !(req_if.valid));
    wait (expected_rsp.size() == 0);
    repeat (500) @(posedge clk_i);
    $display("Checked %0d results: %0d scheduling passes, %0d recomputes.",
             n_checked, n_passes, n_recomputes);
    if (errors == 0 && expected_rsp.size() == 0) begin
      $display("** task_priority_scheduler: PASSED **");
    end else begin
      $display("** task_priority_scheduler: FAILED **");
    end
    $finish;
  end

endmodule

>>> files.f
src/tps_pkg.sv
src/tps_if.sv
src/task_priority_scheduler.sv
test/tb_task_priority_scheduler.sv
